// ===== hdl/dtt_pkg.sv =====
// Shared types and constants for the deadline timer table.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

    // Input opcodes, carried in s_tuser
    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_QUERY  = 2'd2,
        OP_EXPIRE = 2'd3
    } op_t;

    // Result kinds, carried in m_tuser
    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_WAIT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Write command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_NOP    = 2'd0,
        CELL_ARM    = 2'd1,
        CELL_DISARM = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_PUSH = 2'd2
    } state_t;

    localparam int          WAIT_BITS  = 48;
    localparam logic [47:0] WAIT_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam int          FIRE_CNT_W = 5;
    localparam logic [4:0]  MAX_FIRES  = 5'd16;   // fires per expire beat

endpackage

`default_nettype wire

// ===== hdl/deadline_timer_table.sv =====
// Top level of the deadline timer table: beat control and the cell row.
// Depends on dtt_pkg and dtt_cell.
`timescale 1ns / 1ps
`default_nettype none

// A table of NUM_TIMERS one-shot millisecond timers kept in a row of cells,
// one timer per cell. Each cell compares its own deadline with the running
// candidate from its left neighbor and registers the earlier one, so the
// earliest armed deadline (ties to the lower timer number) appears at the
// right end once a full sweep has passed every cell since the table last
// changed. Arm and cancel write the cell and stage an acknowledgement for
// the output register; query sweeps the row, stages its result and then
// loads the output register, as does expire when nothing is due.
// Expire with k timers due runs one sweep per search and holds each claimed
// timer until the next sweep settles its last flag; at most 16 timers fire
// per beat and the rest stay armed. Sink stalls add to each result's wait.
// A new input beat is taken once the previous one's last result sits in the
// output register, even if the sink has not taken it.
// Timer numbers at or above NUM_TIMERS are acknowledged and change nothing.

module deadline_timer_table #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 48
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input beat
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [87:0] s_tdata,   // timer_id[3:0], delay_ms[35:4], now_ms[83:36], zero
    input  wire  [7:0]  s_tuser,   // opcode[1:0], zero
    // result beat
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // fired_id[3:0], wait_ms[51:4], zero
    output logic [7:0]  m_tuser,   // kind[1:0], zero
    output logic        m_tlast
);
    import dtt_pkg::*;

    localparam int IDX_BITS = $clog2(NUM_TIMERS);
    localparam int CNT_BITS = $clog2(NUM_TIMERS + 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // input field split
    op_t                  in_op;
    logic [3:0]           in_timer_id;
    logic [31:0]          in_delay;
    logic [TIME_BITS-1:0] in_now;
    logic [TIME_BITS:0]   arm_sum;
    logic [TIME_BITS-1:0] arm_deadline;
    logic                 in_range;

    assign in_op       = op_t'(s_tuser[1:0]);
    assign in_timer_id = s_tdata[3:0];
    assign in_delay    = s_tdata[35:4];
    assign in_now      = TIME_BITS'(s_tdata[83:36]);
    assign in_range    = (32'(in_timer_id) < NUM_TIMERS);
    assign arm_sum     = {1'b0, in_now} + (TIME_BITS + 1)'(in_delay);
    assign arm_deadline = arm_sum[TIME_BITS] ? TIME_MAX : arm_sum[TIME_BITS-1:0];

    // cell row
    cell_op_t             cell_op;
    logic [IDX_BITS-1:0]  cell_wr_id;
    logic [TIME_BITS-1:0] cell_wr_dl;
    logic                 chain_valid [0:NUM_TIMERS];
    logic [TIME_BITS-1:0] chain_dl    [0:NUM_TIMERS];
    logic [IDX_BITS-1:0]  chain_id    [0:NUM_TIMERS];

    assign chain_valid[0] = 1'b0;
    assign chain_dl[0]    = '0;
    assign chain_id[0]    = '0;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        dtt_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_BITS  (IDX_BITS),
            .CELL_ID   (g)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cell_op      (cell_op),
            .wr_id        (cell_wr_id),
            .wr_deadline  (cell_wr_dl),
            .in_valid     (chain_valid[g]),
            .in_deadline  (chain_dl[g]),
            .in_id        (chain_id[g]),
            .out_valid    (chain_valid[g+1]),
            .out_deadline (chain_dl[g+1]),
            .out_id       (chain_id[g+1])
        );
    end

    // control state
    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 is_exp_reg, is_exp_next;
    logic                 have_pend_reg, have_pend_next;
    logic [IDX_BITS-1:0]  pend_id_reg, pend_id_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;

    // staged result, waiting for the output register
    kind_t                res_kind_reg, res_kind_next;
    logic [3:0]           res_id_reg, res_id_next;
    logic [WAIT_BITS-1:0] res_wait_reg, res_wait_next;
    logic                 res_last_reg, res_last_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [3:0]           out_id_reg, out_id_next;
    logic [WAIT_BITS-1:0] out_wait_reg, out_wait_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 scan_done;
    logic                 out_free;
    logic                 out_load;
    logic                 due;
    logic [TIME_BITS-1:0] wait_diff;
    logic [WAIT_BITS-1:0] wait_sat;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // tail of the row: earliest armed timer after a full sweep
    assign due = chain_valid[NUM_TIMERS] && (chain_dl[NUM_TIMERS] <= now_reg)
                 && (fire_cnt_reg < MAX_FIRES);
    assign wait_diff = (chain_dl[NUM_TIMERS] > now_reg)
                       ? (chain_dl[NUM_TIMERS] - now_reg) : '0;
    assign wait_sat  = (wait_diff > TIME_BITS'(WAIT_MAX)) ? WAIT_MAX
                                                         : WAIT_BITS'(wait_diff);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_op inside {OP_ARM, OP_CANCEL}) begin
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_BITS'(NUM_TIMERS)) begin
                    if (is_exp_reg && !have_pend_reg && due) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = res_last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        scan_done = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_SCAN: scan_done = (cnt_reg == CNT_BITS'(NUM_TIMERS));
            ST_PUSH: out_load  = out_free;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        is_exp_next    = is_exp_reg;
        have_pend_next = have_pend_reg;
        pend_id_next   = pend_id_reg;
        fire_cnt_next  = fire_cnt_reg;
        res_kind_next  = res_kind_reg;
        res_id_next    = res_id_reg;
        res_wait_next  = res_wait_reg;
        res_last_next  = res_last_reg;
        cell_op        = CELL_NOP;
        cell_wr_id     = IDX_BITS'(in_timer_id);
        cell_wr_dl     = arm_deadline;

        if (state_reg == ST_SCAN) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (accept) begin
            now_next       = in_now;
            is_exp_next    = (in_op == OP_EXPIRE);
            have_pend_next = 1'b0;
            fire_cnt_next  = '0;
            cnt_next       = '0;
            res_kind_next  = KIND_ACK;
            res_id_next    = '0;
            res_wait_next  = '0;
            res_last_next  = 1'b1;
            if (in_range && (in_op == OP_ARM)) begin
                cell_op = CELL_ARM;
            end else if (in_range && (in_op == OP_CANCEL)) begin
                cell_op = CELL_DISARM;
            end
        end

        if (scan_done) begin
            cnt_next = '0;
            if (!is_exp_reg) begin
                res_kind_next = chain_valid[NUM_TIMERS] ? KIND_WAIT : KIND_NONE;
                res_id_next   = '0;
                res_wait_next = chain_valid[NUM_TIMERS] ? wait_sat : '0;
                res_last_next = 1'b1;
            end else begin
                if (have_pend_reg) begin
                    // the held timer goes out; last unless another one is due
                    res_kind_next = KIND_FIRED;
                    res_id_next   = 4'(pend_id_reg);
                    res_wait_next = '0;
                    res_last_next = !due;
                end else if (!due) begin
                    res_kind_next = KIND_NONE;
                    res_id_next   = '0;
                    res_wait_next = '0;
                    res_last_next = 1'b1;
                end
                if (due) begin
                    cell_op        = CELL_DISARM;
                    cell_wr_id     = chain_id[NUM_TIMERS];
                    have_pend_next = 1'b1;
                    pend_id_next   = chain_id[NUM_TIMERS];
                    fire_cnt_next  = fire_cnt_reg + 1'b1;
                end
            end
        end

        if (out_load) begin
            cnt_next = '0;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_wait_next  = out_wait_reg;
        out_last_next  = out_last_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind_reg;
            out_id_next    = res_id_reg;
            out_wait_next  = res_wait_reg;
            out_last_next  = res_last_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            is_exp_reg    <= 1'b0;
            have_pend_reg <= 1'b0;
            fire_cnt_reg  <= '0;
            res_last_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            is_exp_reg    <= is_exp_next;
            have_pend_reg <= have_pend_next;
            fire_cnt_reg  <= fire_cnt_next;
            res_last_reg  <= res_last_next;
            out_valid_reg <= out_valid_next;
        end
        now_reg      <= now_next;
        pend_id_reg  <= pend_id_next;
        res_kind_reg <= res_kind_next;
        res_id_reg   <= res_id_next;
        res_wait_reg <= res_wait_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_wait_reg <= out_wait_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_wait_reg, out_id_reg};
    assign m_tuser  = {6'b0, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/dtt_cell.sv =====
// One timer cell: holds a deadline and an armed flag, and passes the
// running earliest-deadline candidate on to the next cell. Uses dtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtt_cell #(
    parameter int TIME_BITS = 48,
    parameter int IDX_BITS  = 4,
    parameter int CELL_ID   = 0
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  dtt_pkg::cell_op_t        cell_op,
    input  wire  [IDX_BITS-1:0]      wr_id,
    input  wire  [TIME_BITS-1:0]     wr_deadline,
    input  wire                      in_valid,
    input  wire  [TIME_BITS-1:0]     in_deadline,
    input  wire  [IDX_BITS-1:0]      in_id,
    output logic                     out_valid,
    output logic [TIME_BITS-1:0]     out_deadline,
    output logic [IDX_BITS-1:0]      out_id
);
    import dtt_pkg::*;

    logic                 armed_reg, armed_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic                 cand_valid_reg, cand_valid_next;
    logic [TIME_BITS-1:0] cand_dl_reg, cand_dl_next;
    logic [IDX_BITS-1:0]  cand_id_reg, cand_id_next;
    logic                 hit;
    logic                 take;

    assign hit  = (wr_id == IDX_BITS'(CELL_ID));
    // strict compare keeps the lower-numbered timer on a tie
    assign take = armed_reg && (!in_valid || (deadline_reg < in_deadline));

    always_comb begin
        armed_next    = armed_reg;
        deadline_next = deadline_reg;
        if (hit && (cell_op == CELL_ARM)) begin
            armed_next    = 1'b1;
            deadline_next = wr_deadline;
        end else if (hit && (cell_op == CELL_DISARM)) begin
            armed_next = 1'b0;
        end
        if (take) begin
            cand_valid_next = 1'b1;
            cand_dl_next    = deadline_reg;
            cand_id_next    = IDX_BITS'(CELL_ID);
        end else begin
            cand_valid_next = in_valid;
            cand_dl_next    = in_deadline;
            cand_id_next    = in_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            cand_valid_reg <= 1'b0;
        end else begin
            armed_reg      <= armed_next;
            cand_valid_reg <= cand_valid_next;
        end
        deadline_reg <= deadline_next;
        cand_dl_reg  <= cand_dl_next;
        cand_id_reg  <= cand_id_next;
    end

    assign out_valid    = cand_valid_reg;
    assign out_deadline = cand_dl_reg;
    assign out_id       = cand_id_reg;

endmodule

`default_nettype wire

// ===== hdl/dtt_checker.sv =====
// Port-level checks for deadline_timer_table, bound to the top level.
// Depends on dtt_pkg and deadline_timer_table.
`timescale 1ns / 1ps
`default_nettype none

module dtt_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire [7:0]  m_tuser,
    input wire        m_tlast
);
    import dtt_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // one input beat at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a beat");

    // only fired results may continue a run
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != KIND_FIRED) |-> m_tlast)
        else $error("non-fired result without last");

    // wait field is zero outside next-delay results, id zero outside fires
    a_field_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[1:0] == KIND_WAIT) || (m_tdata[51:4] == '0))
                  && ((m_tuser[1:0] == KIND_FIRED) || (m_tdata[3:0] == '0)))
        else $error("unused result field not zero");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/deadline_timer_table_tb.sv =====
// Self-checking testbench for deadline_timer_table: arm, cancel, query and expire traffic.
// Depends on dtt_pkg and on the deadline_timer_table RTL; keeps its own model of the table.
`timescale 1ns / 1ps

module deadline_timer_table_tb;
    import dtt_pkg::*;

    localparam int          TIMERS      = 16;
    localparam int          TBITS       = 48;
    localparam logic [47:0] TIME_TOP    = 48'hFFFF_FFFF_FFFF;  // largest TBITS value
    localparam int          FIRE_LIMIT  = 16;                  // fires per expire beat
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          TAIL_CYCLES = 60;                  // quiet time after last result

    typedef struct {
        kind_t       kind;
        logic [3:0]  fired_id;
        logic [47:0] wait_ms;
        logic        is_last;
    } timer_outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;   // timer_id[3:0], delay_ms[35:4], now_ms[83:36], zero
    logic [7:0]  s_tuser  = '0;   // opcode[1:0], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // fired_id[3:0], wait_ms[51:4], zero
    logic [7:0]  m_tuser;         // kind[1:0], zero
    logic        m_tlast;

    // model of the table
    logic [47:0]    tt_deadline [TIMERS];
    logic           tt_armed    [TIMERS];
    timer_outcome_t timer_outcomes[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          beats_in       = 0;
    int          beats_out      = 0;
    int          fires_seen     = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int          hold_left      = 0;
    logic [47:0] cur_now        = 48'd1000;

    deadline_timer_table #(
        .NUM_TIMERS(TIMERS),
        .TIME_BITS (TBITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, timer_outcomes.size());
            $display("status: fail");
            $finish;
        end
    end

    // Sink side: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic int earliest_armed();
        int best;
        best = -1;
        for (int i = 0; i < TIMERS; i++)
            if (tt_armed[i] && (best < 0 || tt_deadline[i] < tt_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic timer_outcome_t outcome(input kind_t k, input logic [3:0] id,
                                               input logic [47:0] w, input logic lst);
        timer_outcome_t o;
        o.kind     = k;
        o.fired_id = id;
        o.wait_ms  = w;
        o.is_last  = lst;
        return o;
    endfunction

    // Apply one accepted command to the table model and queue what it causes.
    task automatic timer_table_step(input op_t op, input logic [3:0] id,
                                    input logic [31:0] delay, input logic [47:0] now_ms);
        logic [48:0] sum;
        logic [47:0] w;
        int          e;
        int          n;
        logic [3:0]  fired [FIRE_LIMIT];
        case (op)
            OP_ARM, OP_CANCEL: begin
                if (op == OP_ARM) begin
                    sum = {1'b0, now_ms} + {17'd0, delay};
                    tt_deadline[id] = (sum > {1'b0, TIME_TOP}) ? TIME_TOP : sum[47:0];
                    tt_armed[id]    = 1'b1;
                end else begin
                    tt_armed[id] = 1'b0;
                end
                timer_outcomes.push_back(outcome(KIND_ACK, 4'd0, 48'd0, 1'b1));
            end
            OP_QUERY: begin
                e = earliest_armed();
                if (e < 0) begin
                    timer_outcomes.push_back(outcome(KIND_NONE, 4'd0, 48'd0, 1'b1));
                end else begin
                    w = (tt_deadline[e] > now_ms) ? tt_deadline[e] - now_ms : 48'd0;
                    timer_outcomes.push_back(outcome(KIND_WAIT, 4'd0, w, 1'b1));
                end
            end
            default: begin
                n = 0;
                while (n < FIRE_LIMIT) begin
                    e = earliest_armed();
                    if (e < 0 || tt_deadline[e] > now_ms)
                        break;
                    tt_armed[e] = 1'b0;
                    fired[n]    = e[3:0];
                    n++;
                end
                if (n == 0)
                    timer_outcomes.push_back(outcome(KIND_NONE, 4'd0, 48'd0, 1'b1));
                for (int i = 0; i < n; i++)
                    timer_outcomes.push_back(outcome(KIND_FIRED, fired[i], 48'd0,
                                                     (i == n - 1)));
            end
        endcase
    endtask

    // Offer one command beat and wait for it to be taken. Valid is left high on
    // return; the caller sends again or drains in the same step.
    task automatic send_cmd(input op_t op, input logic [3:0] id,
                            input logic [31:0] delay, input logic [47:0] now_ms);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, now_ms, delay, id};
        s_tuser  <= {6'd0, op};
        do @(posedge aclk); while (!s_tready);
        beats_in++;
        timer_table_step(op, id, delay, now_ms);
    endtask

    task automatic wait_for_outcomes();
        s_tvalid <= 1'b0;
        while (timer_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    // Compare every result beat with the oldest outstanding prediction.
    always @(posedge aclk) begin : check_results
        timer_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (m_tuser[1:0] == KIND_FIRED)
                fires_seen++;
            if (timer_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d id %0d",
                                          m_tuser[1:0], m_tdata[3:0]));
            end else begin
                want = timer_outcomes.pop_front();
                if (m_tuser[1:0] !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d",
                                              m_tuser[1:0], want.kind));
                if (m_tdata[3:0] !== want.fired_id)
                    report_mismatch($sformatf("fired_id %0d, want %0d",
                                              m_tdata[3:0], want.fired_id));
                if (m_tdata[51:4] !== want.wait_ms)
                    report_mismatch($sformatf("wait_ms %0d, want %0d",
                                              m_tdata[51:4], want.wait_ms));
                if (m_tlast !== want.is_last)
                    report_mismatch($sformatf("tlast %0b, want %0b",
                                              m_tlast, want.is_last));
            end
        end
    end

    // Empty table, idle cancel, re-arm replacing a deadline, due exactly at the
    // deadline, and a deadline that saturates at the top of the time range.
    task automatic test_edge_cases();
        send_cmd(OP_QUERY,  4'd0,  32'd0,         48'd0);
        send_cmd(OP_EXPIRE, 4'd0,  32'd0,         48'd0);
        send_cmd(OP_CANCEL, 4'd3,  32'd0,         48'd5);
        send_cmd(OP_ARM,    4'd0,  32'd0,         48'd10);
        send_cmd(OP_ARM,    4'd15, 32'hFFFF_FFFF, TIME_TOP - 48'd3);
        send_cmd(OP_ARM,    4'd0,  32'd40,        48'd10);
        send_cmd(OP_QUERY,  4'd0,  32'd0,         48'd20);
        send_cmd(OP_EXPIRE, 4'd0,  32'd0,         48'd50);
        send_cmd(OP_EXPIRE, 4'd0,  32'd0,         TIME_TOP);
        wait_for_outcomes();
    endtask

    // Every timer armed, deadlines in tie groups, one expire that fires them all.
    task automatic test_full_table_expire();
        for (int i = 0; i < TIMERS; i++)
            send_cmd(OP_ARM, i[3:0], 32'(((15 - i) % 5) * 3), 48'd1000);
        send_cmd(OP_EXPIRE, 4'd0, 32'd0, 48'd2000);
        wait_for_outcomes();
    endtask

    // Mostly well-formed traffic on a moving clock, with some random noise beats.
    task automatic test_random_traffic(input int count, input int unsigned src_pct,
                                       input int unsigned sink_pct);
        int unsigned pick;
        int unsigned dsel;
        logic [31:0] delay;
        logic [47:0] stamp;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int n = 0; n < count; n++) begin
            cur_now += $urandom_range(0, 24);
            pick = $urandom_range(99);
            dsel = $urandom_range(9);
            if (dsel <= 6)      delay = $urandom_range(1, 120);
            else if (dsel == 7) delay = 32'd0;
            else if (dsel == 8) delay = $urandom;
            else                delay = 32'hFFFF_FFFF;
            if (pick < 38)
                send_cmd(OP_ARM, 4'($urandom_range(15)), delay, cur_now);
            else if (pick < 48)
                send_cmd(OP_CANCEL, 4'($urandom_range(15)), delay, cur_now);
            else if (pick < 66)
                send_cmd(OP_QUERY, 4'($urandom_range(15)), delay, cur_now);
            else if (pick < 94)
                send_cmd(OP_EXPIRE, 4'($urandom_range(15)), delay, cur_now);
            else begin
                // one-off beat with a random time stamp, any opcode
                stamp = 48'({$urandom, $urandom});
                send_cmd(op_t'($urandom_range(3)), 4'($urandom_range(15)), $urandom,
                         stamp);
            end
        end
        wait_for_outcomes();
    endtask

    // Sink holds off for a long stretch while commands keep coming, so the
    // block's output fills and s_tready drops.
    task automatic test_backpressure_fill();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 500;
        for (int n = 0; n < 20; n++) begin
            cur_now += 3;
            case (n % 4)
                0, 1: send_cmd(OP_ARM, 4'($urandom_range(15)), $urandom_range(0, 20),
                               cur_now);
                2:    send_cmd(OP_QUERY, 4'd0, 32'd0, cur_now);
                default: send_cmd(OP_EXPIRE, 4'd0, 32'd0, cur_now);
            endcase
        end
        wait_for_outcomes();
    endtask

    initial begin
        for (int i = 0; i < TIMERS; i++) begin
            tt_deadline[i] = '0;
            tt_armed[i]    = 1'b0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_cases();
        test_full_table_expire();
        test_random_traffic(85, 0, 0);
        test_random_traffic(85, 88, 0);
        test_random_traffic(85, 0, 88);
        test_random_traffic(85, 10, 10);
        test_backpressure_fill();

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("ran %0d command beats (%0d result beats, %0d timer fires)",
                 beats_in, beats_out, fires_seen);
        $display("phases: directed, free flow, idle source, stalling sink, both, long hold-off");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
